@@ rtl/vdft_pkg.sv @@
// Shared types and constants for the vertex dedup fan triangulator.
package vdft_pkg;

  // Default sizing of the triple table and of one stored index.
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int INDEX_BITS_DEF  = 16;

  // Fixed widths of the port fields.
  localparam int FIELD_W = 16;
  localparam int VNUM_W  = 10;
  localparam int TOTAL_W = 32;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // load a corner at its input transfer
    logic scan;    // step the table search
    logic commit;  // update table and fan, load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // the registered table word matches the key
    logic miss;      // every used entry was compared without a match
    logic out_free;  // the result register can take a new result
  } status_t;

endpackage

@@ rtl/vdft_ctrl.sv @@
// Controller state machine: sequences transfer, table search and commit.
module vdft_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  vdft_pkg::status_t st,
  output vdft_pkg::cmd_t    cmd
);

  vdft_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vdft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vdft_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = vdft_pkg::ST_SCAN;
        end
      end
      vdft_pkg::ST_SCAN: begin
        if (st.hit || st.miss) begin
          state_nxt = vdft_pkg::ST_COMMIT;
        end
      end
      vdft_pkg::ST_COMMIT: begin
        if (st.out_free) begin
          state_nxt = vdft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vdft_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      vdft_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      vdft_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      vdft_pkg::ST_COMMIT: begin
        cmd.commit = st.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/vdft_datapath.sv @@
// Datapath: triple table memory, linear search, fan state and result register.
module vdft_datapath #(
  parameter int TABLE_DEPTH = vdft_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_BITS  = vdft_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vdft_pkg::cmd_t               cmd,
  output vdft_pkg::status_t            st,
  input  logic [vdft_pkg::FIELD_W-1:0] in_pos_index,
  input  logic [vdft_pkg::FIELD_W-1:0] in_tex_index,
  input  logic [vdft_pkg::FIELD_W-1:0] in_norm_index,
  input  logic                         in_poly_start,
  input  logic                         in_clear_mesh,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vdft_pkg::VNUM_W-1:0]  out_vertex_number,
  output logic                         out_is_new,
  output logic                         out_tri_valid,
  output logic [vdft_pkg::VNUM_W-1:0]  out_tri_first,
  output logic [vdft_pkg::VNUM_W-1:0]  out_tri_second,
  output logic [vdft_pkg::VNUM_W-1:0]  out_tri_third,
  output logic                         out_table_full,
  output logic [vdft_pkg::TOTAL_W-1:0] out_triangle_total
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int KW = 3 * INDEX_BITS;
  localparam int VW = vdft_pkg::VNUM_W;
  localparam int TW = vdft_pkg::TOTAL_W;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  // Triple table; entries at and above entries_r are never read.
  logic [KW-1:0] mem [TABLE_DEPTH];
  logic [KW-1:0] mem_q;

  logic [KW-1:0] key_r;
  logic [CW-1:0] entries_r;
  logic [CW-1:0] scan_idx_r;
  logic [AW-1:0] rd_addr_r;
  logic          rd_pend_r;
  logic          found_r;
  logic [AW-1:0] slot_r;
  logic [VW-1:0] anchor_r;
  logic [VW-1:0] prev_r;
  logic [1:0]    corners_r;
  logic [TW-1:0] tri_cnt_r;
  logic          out_valid_r;

  logic          issue;
  logic          new_ok;
  logic          ok;
  logic [AW-1:0] slot_sel;
  logic [VW-1:0] vnum;
  logic          tri_emit;
  logic [TW-1:0] tri_cnt_nxt;
  logic [KW-1:0] key_in;

  // Key of the incoming corner, each index cut or extended to INDEX_BITS.
  assign key_in = {INDEX_BITS'(in_norm_index), INDEX_BITS'(in_tex_index),
                   INDEX_BITS'(in_pos_index)};

  // One table read per search cycle; the compare is made on the registered word in the next cycle.
  assign issue   = cmd.scan && (scan_idx_r < entries_r);
  assign st.hit  = rd_pend_r && (mem_q == key_r);
  assign st.miss = !rd_pend_r && (scan_idx_r >= entries_r);
  assign st.out_free = !out_valid_r || out_ready;

  // Commit decisions from the search outcome.
  assign new_ok   = !found_r && (entries_r < DEPTH_CNT);
  assign ok       = found_r || new_ok;
  assign slot_sel = found_r ? slot_r : (new_ok ? entries_r[AW-1:0] : '0);
  assign vnum     = VW'(slot_sel);
  assign tri_emit = ok && (corners_r == 2'd2);
  assign tri_cnt_nxt = (tri_emit && (tri_cnt_r != '1)) ? tri_cnt_r + TW'(1) : tri_cnt_r;

  // Table memory: written at commit of a new triple, read during search.
  always_ff @(posedge clk) begin
    if (cmd.commit && new_ok) begin
      mem[entries_r[AW-1:0]] <= key_r;
    end
    if (issue) begin
      mem_q <= mem[scan_idx_r[AW-1:0]];
    end
  end

  // Search payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= key_in;
    end
    if (issue) begin
      rd_addr_r <= scan_idx_r[AW-1:0];
    end
    if (cmd.scan && st.hit) begin
      slot_r <= rd_addr_r;
    end
  end

  // Search control and mesh state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r  <= '0;
      scan_idx_r <= '0;
      rd_pend_r  <= 1'b0;
      found_r    <= 1'b0;
      anchor_r   <= '0;
      prev_r     <= '0;
      corners_r  <= '0;
      tri_cnt_r  <= '0;
    end else begin
      if (cmd.start) begin
        scan_idx_r <= '0;
        rd_pend_r  <= 1'b0;
        found_r    <= 1'b0;
        if (in_clear_mesh) begin
          entries_r <= '0;
          anchor_r  <= '0;
          prev_r    <= '0;
          tri_cnt_r <= '0;
        end
        if (in_clear_mesh || in_poly_start) begin
          corners_r <= '0;
        end
      end
      if (cmd.scan) begin
        rd_pend_r <= issue;
        if (issue) begin
          scan_idx_r <= scan_idx_r + CW'(1);
        end
        if (st.hit) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (new_ok) begin
          entries_r <= entries_r + CW'(1);
        end
        tri_cnt_r <= tri_cnt_nxt;
        if (ok) begin
          prev_r <= vnum;
          unique case (corners_r)
            2'd0: begin
              anchor_r  <= vnum;
              corners_r <= 2'd1;
            end
            default: begin
              corners_r <= 2'd2;
            end
          endcase
        end
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_vertex_number  <= vnum;
      out_is_new         <= new_ok;
      out_tri_valid      <= tri_emit;
      out_tri_first      <= tri_emit ? anchor_r : '0;
      out_tri_second     <= tri_emit ? prev_r : '0;
      out_tri_third      <= tri_emit ? vnum : '0;
      out_table_full     <= !ok;
      out_triangle_total <= tri_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/vertex_dedup_fan_triangulator.sv @@
// Top level of the vertex dedup fan triangulator.
//
// One polygon corner (position, texcoord and normal index) is taken per
// input transfer on in_valid/in_ready; one result leaves per transfer on
// out_valid/out_ready. The corner's triple is searched linearly in a
// table memory, one entry per cycle; a new triple takes the next free
// slot if any, and its slot is the vertex number. From the third corner
// of a polygon on, a fan triangle is reported with the result.
// The next corner is taken in the cycle after the result is loaded.
// The table read port gives one compare per cycle.
// A result waiting on out_ready does not stop the next corner from being
// taken and searched; that corner then waits before its commit.
// Reset empties the table by clearing its fill count and zeroes the fan
// state and triangle count; no clearing pass is needed.
module vertex_dedup_fan_triangulator #(
  parameter int TABLE_DEPTH = vdft_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_BITS  = vdft_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [vdft_pkg::FIELD_W-1:0] in_pos_index,
  input  logic [vdft_pkg::FIELD_W-1:0] in_tex_index,
  input  logic [vdft_pkg::FIELD_W-1:0] in_norm_index,
  input  logic                         in_poly_start,
  input  logic                         in_clear_mesh,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vdft_pkg::VNUM_W-1:0]  out_vertex_number,
  output logic                         out_is_new,
  output logic                         out_tri_valid,
  output logic [vdft_pkg::VNUM_W-1:0]  out_tri_first,
  output logic [vdft_pkg::VNUM_W-1:0]  out_tri_second,
  output logic [vdft_pkg::VNUM_W-1:0]  out_tri_third,
  output logic                         out_table_full,
  output logic [vdft_pkg::TOTAL_W-1:0] out_triangle_total
);

  vdft_pkg::cmd_t    cmd;
  vdft_pkg::status_t st;

  // Sequencer.
  vdft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Table, fan state and result register.
  vdft_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_pos_index       (in_pos_index),
    .in_tex_index       (in_tex_index),
    .in_norm_index      (in_norm_index),
    .in_poly_start      (in_poly_start),
    .in_clear_mesh      (in_clear_mesh),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_vertex_number  (out_vertex_number),
    .out_is_new         (out_is_new),
    .out_tri_valid      (out_tri_valid),
    .out_tri_first      (out_tri_first),
    .out_tri_second     (out_tri_second),
    .out_tri_third      (out_tri_third),
    .out_table_full     (out_table_full),
    .out_triangle_total (out_triangle_total)
  );

endmodule

@@ rtl/vdft_checker.sv @@
// Port-level checks for the vertex dedup fan triangulator, bound to the top level.
module vdft_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [vdft_pkg::VNUM_W-1:0]  out_vertex_number,
  input logic                         out_is_new,
  input logic                         out_tri_valid,
  input logic                         out_table_full,
  input logic [vdft_pkg::TOTAL_W-1:0] out_triangle_total
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_number)
      && $stable(out_triangle_total))
    else $error("result changed while stalled");

  // A dropped corner never carries a triangle.
  a_full_no_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_tri_valid)
    else $error("triangle reported with a full table");

  // A dropped corner has no vertex and no new entry.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> (out_vertex_number == '0) && !out_is_new)
    else $error("full table result not cleared");

  // A reported triangle is counted.
  a_tri_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tri_valid |-> out_triangle_total != '0)
    else $error("triangle not counted");

endmodule

bind vertex_dedup_fan_triangulator vdft_checker u_vdft_checker (.*);

@@ test/tb_vertex_dedup_fan_triangulator.sv @@
// Self-checking testbench for the vertex dedup fan triangulator.
`timescale 1ns / 100ps

module tb_vertex_dedup_fan_triangulator;

  localparam int DEPTH      = vdft_pkg::TABLE_DEPTH_DEF;
  localparam int IDX_BITS   = vdft_pkg::INDEX_BITS_DEF;
  localparam int KEY_W      = 3 * IDX_BITS;
  localparam int CYCLE_CAP  = 4000000;
  localparam int HOLD_AT    = 1300;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 450;

  typedef struct {
    logic [vdft_pkg::FIELD_W-1:0] pos;
    logic [vdft_pkg::FIELD_W-1:0] tex;
    logic [vdft_pkg::FIELD_W-1:0] norm;
    logic                         poly_start;
    logic                         clear_mesh;
    bit                           wait_drain;
  } corner_t;

  typedef struct {
    logic [vdft_pkg::VNUM_W-1:0]  vnum;
    logic                         is_new;
    logic                         tri_valid;
    logic [vdft_pkg::VNUM_W-1:0]  tri_first;
    logic [vdft_pkg::VNUM_W-1:0]  tri_second;
    logic [vdft_pkg::VNUM_W-1:0]  tri_third;
    logic                         full;
    logic [vdft_pkg::TOTAL_W-1:0] total;
  } corner_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [vdft_pkg::FIELD_W-1:0] in_pos_index = '0;
  logic [vdft_pkg::FIELD_W-1:0] in_tex_index = '0;
  logic [vdft_pkg::FIELD_W-1:0] in_norm_index = '0;
  logic in_poly_start = 1'b0;
  logic in_clear_mesh = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [vdft_pkg::VNUM_W-1:0] out_vertex_number;
  logic out_is_new;
  logic out_tri_valid;
  logic [vdft_pkg::VNUM_W-1:0] out_tri_first;
  logic [vdft_pkg::VNUM_W-1:0] out_tri_second;
  logic [vdft_pkg::VNUM_W-1:0] out_tri_third;
  logic out_table_full;
  logic [vdft_pkg::TOTAL_W-1:0] out_triangle_total;

  // Corners waiting to be offered and outcomes waiting to come back.
  corner_t corner_queue[$];
  corner_outcome_t awaited_outcomes[$];

  // Shadow copy of the triple table and the fan state.
  logic [KEY_W-1:0] seen_triples[DEPTH];
  int unsigned triples_used = 0;
  logic [vdft_pkg::VNUM_W-1:0] anchor_vnum = '0;
  logic [vdft_pkg::VNUM_W-1:0] prev_vnum = '0;
  int unsigned corners_in_fan = 0;
  logic [vdft_pkg::TOTAL_W-1:0] triangles_made = '0;

  int mismatch_count = 0;
  int corners_sent = 0;
  int outcomes_seen = 0;
  longint cycle_count = 0;

  corner_t cur_corner;
  int send_gap = 0;
  bit slot_free;
  corner_outcome_t want;
  int recv_stall = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  vertex_dedup_fan_triangulator #(
    .TABLE_DEPTH(DEPTH),
    .INDEX_BITS (IDX_BITS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pos_index      (in_pos_index),
    .in_tex_index      (in_tex_index),
    .in_norm_index     (in_norm_index),
    .in_poly_start     (in_poly_start),
    .in_clear_mesh     (in_clear_mesh),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vertex_number (out_vertex_number),
    .out_is_new        (out_is_new),
    .out_tri_valid     (out_tri_valid),
    .out_tri_first     (out_tri_first),
    .out_tri_second    (out_tri_second),
    .out_tri_third     (out_tri_third),
    .out_table_full    (out_table_full),
    .out_triangle_total(out_triangle_total)
  );

  // Clock and reset.
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Look the corner up in the shadow table, extend the fan and return what the
  // block should report for it.
  function automatic corner_outcome_t resolve_corner(corner_t c);
    corner_outcome_t r;
    logic [KEY_W-1:0] key;
    int slot;
    bit hit;
    logic [vdft_pkg::VNUM_W-1:0] vn;
    r = '{default: '0};
    if (c.clear_mesh) begin
      triples_used = 0;
      anchor_vnum = '0;
      prev_vnum = '0;
      corners_in_fan = 0;
      triangles_made = '0;
    end
    if (c.poly_start) begin
      corners_in_fan = 0;
    end
    key = {c.norm[IDX_BITS-1:0], c.tex[IDX_BITS-1:0], c.pos[IDX_BITS-1:0]};
    slot = 0;
    hit = 1'b0;
    for (int i = 0; i < triples_used; i++) begin
      if (!hit && seen_triples[i] == key) begin
        slot = i;
        hit = 1'b1;
      end
    end
    // A new triple takes the next free slot, or is dropped when none is left.
    if (!hit) begin
      if (triples_used < DEPTH) begin
        slot = triples_used;
        seen_triples[slot] = key;
        triples_used++;
        r.is_new = 1'b1;
        hit = 1'b1;
      end else begin
        r.full = 1'b1;
        slot = 0;
      end
    end
    vn = vdft_pkg::VNUM_W'(slot);
    // The fan advances only for corners that got a vertex number.
    if (hit) begin
      if (corners_in_fan == 0) begin
        anchor_vnum = vn;
        prev_vnum = vn;
        corners_in_fan = 1;
      end else if (corners_in_fan == 1) begin
        prev_vnum = vn;
        corners_in_fan = 2;
      end else begin
        r.tri_valid = 1'b1;
        r.tri_first = anchor_vnum;
        r.tri_second = prev_vnum;
        r.tri_third = vn;
        prev_vnum = vn;
        if (triangles_made != '1) begin
          triangles_made = triangles_made + 1'b1;
        end
      end
    end
    r.vnum = vn;
    r.total = triangles_made;
    return r;
  endfunction

  function automatic void add_corner(logic [15:0] p, logic [15:0] t, logic [15:0] n,
                                     bit ps, bit cm, bit drain);
    corner_t c;
    c.pos = p;
    c.tex = t;
    c.norm = n;
    c.poly_start = ps;
    c.clear_mesh = cm;
    c.wait_drain = drain;
    corner_queue.insert(corner_queue.size(), c);
  endfunction

  // Mostly a small pool so triples repeat, sometimes absent, sometimes any value.
  function automatic logic [15:0] pick_index();
    int sel;
    sel = $urandom_range(0, 23);
    if (sel < 4) begin
      return '0;
    end else if (sel < 7) begin
      return 16'($urandom_range(0, 65535));
    end
    return 16'($urandom_range(0, 7));
  endfunction

  // Idle cycles before the next transfer; zero across quiet stretches.
  function automatic int draw_wait(bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void check_field(string name, longint unsigned exp_val,
                                      longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  // Input driver: offers queued corners and predicts each one on its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      slot_free = !in_valid;
      if (in_valid && in_ready) begin
        awaited_outcomes.insert(awaited_outcomes.size(), resolve_corner(cur_corner));
        corners_sent++;
        slot_free = 1'b1;
        send_gap = draw_wait((corners_sent / 150) % 3 == 2);
      end
      if (slot_free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (corner_queue.size() != 0 &&
                     (!corner_queue[0].wait_drain || awaited_outcomes.size() == 0)) begin
          cur_corner = corner_queue.pop_front();
          in_valid <= 1'b1;
          in_pos_index <= cur_corner.pos;
          in_tex_index <= cur_corner.tex;
          in_norm_index <= cur_corner.norm;
          in_poly_start <= cur_corner.poly_start;
          in_clear_mesh <= cur_corner.clear_mesh;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off of the receiver so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (outcomes_seen >= HOLD_AT && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: compares each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result transfer with no expectation waiting");
          mismatch_count++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("vertex_number", want.vnum, out_vertex_number);
          check_field("is_new", want.is_new, out_is_new);
          check_field("tri_valid", want.tri_valid, out_tri_valid);
          check_field("tri_first", want.tri_first, out_tri_first);
          check_field("tri_second", want.tri_second, out_tri_second);
          check_field("tri_third", want.tri_third, out_tri_third);
          check_field("table_full", want.full, out_table_full);
          check_field("triangle_total", want.total, out_triangle_total);
        end
        outcomes_seen++;
        recv_stall = draw_wait((outcomes_seen / 170) % 3 == 0);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_ready <= (recv_stall == 0 && hold_left == 0);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_vertex_dedup_fan_triangulator: done, errors");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int made;
    int len;
    bit clr;

    // Directed: extremes, repeats, short polygons and clears mid-polygon.
    add_corner(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0);
    add_corner(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_corner(16'h0001, 16'h0002, 16'h0003, 1'b0, 1'b0, 1'b0);
    add_corner(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_corner(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_corner(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_corner(16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_corner(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b0);
    add_corner(16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0, 1'b0);
    add_corner(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_corner(16'h0001, 16'h0002, 16'h0003, 1'b1, 1'b0, 1'b0);
    add_corner(16'h0001, 16'h0002, 16'h0003, 1'b0, 1'b0, 1'b0);
    add_corner(16'h0001, 16'h0002, 16'h0003, 1'b0, 1'b0, 1'b0);
    add_corner(16'h1234, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0);
    add_corner(16'h1234, 16'h0000, 16'h0001, 1'b0, 1'b0, 1'b0);
    add_corner(16'h1234, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_corner(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0);
    add_corner(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 1'b0);
    add_corner(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);

    // Fill every table entry after a drained pause, in polygons of six corners.
    for (int i = 0; i < DEPTH; i++) begin
      add_corner(16'(i), 16'(16'hFFFF - i), 16'(i * 7), (i % 6) == 0, i == 0, i == 0);
    end
    // Full table: new triples are dropped, known ones still build the fan.
    add_corner(16'd2000, 16'd1, 16'd1, 1'b1, 1'b0, 1'b0);
    add_corner(16'd5, 16'(16'hFFFF - 5), 16'd35, 1'b0, 1'b0, 1'b0);
    add_corner(16'd6, 16'(16'hFFFF - 6), 16'd42, 1'b0, 1'b0, 1'b0);
    add_corner(16'd5, 16'd0, 16'd35, 1'b0, 1'b0, 1'b0);
    add_corner(16'd7, 16'(16'hFFFF - 7), 16'd49, 1'b0, 1'b0, 1'b0);
    add_corner(16'd1023, 16'(16'hFFFF - 1023), 16'(1023 * 7), 1'b0, 1'b0, 1'b0);

    // Random: mostly whole polygons from a small index pool, some noise corners.
    made = 0;
    while (made < RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        add_corner(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 19) == 0, 1'b0);
        made++;
      end else begin
        len = $urandom_range(1, 8);
        clr = (made == 0) || ($urandom_range(0, 39) == 0);
        for (int k = 0; k < len; k++) begin
          add_corner(pick_index(), pick_index(), pick_index(), k == 0,
                     clr && k == 0, made == 0);
          made++;
        end
      end
    end

    while (corner_queue.size() != 0 || in_valid) @(posedge clk);
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_vertex_dedup_fan_triangulator: done, clean");
    end else begin
      $display("tb_vertex_dedup_fan_triangulator: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/vdft_pkg.sv
rtl/vdft_ctrl.sv
rtl/vdft_datapath.sv
rtl/vertex_dedup_fan_triangulator.sv
rtl/vdft_checker.sv
test/tb_vertex_dedup_fan_triangulator.sv
